// ----- hdl/stc_pkg.sv -----
// Package: format table, mode codes and pipeline context for the timecode converter.
package stc_pkg;

  localparam int CNT_W = 32;

  localparam logic [1:0] MODE_TO_HMSF  = 2'd0;
  localparam logic [1:0] MODE_TO_COUNT = 2'd1;
  localparam logic [1:0] MODE_ADD      = 2'd2;
  localparam logic [1:0] MODE_SUB      = 2'd3;

  localparam logic [4:0] FMT_LAST = 5'd16;

  localparam logic [32:0] TWO32 = 33'h1_0000_0000;

  localparam logic [31:0] BASE60     = 32'd60;
  localparam logic [31:0] BASE60_RCP = 32'(TWO32 / 60);

  // Per-format divisors and their reciprocals floor(2^32 / d).
  typedef struct packed {
    logic        is_drop;
    logic [2:0]  drop;
    logic [6:0]  fps;
    logic [31:0] fps_rcp;
    logic [31:0] day;
    logic [31:0] day_rcp;
    logic [31:0] fp10;
    logic [31:0] fp10_rcp;
    logic [31:0] fpm;
    logic [31:0] fpm_rcp;
  } fmt_info_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        err;
    logic        roll;
    fmt_info_t   info;
    logic [31:0] cnt;
    logic [15:0] h;
    logic [5:0]  m;
    logic [5:0]  s;
    logic [6:0]  f;
    logic [31:0] t1;
    logic [31:0] dr;
    logic [31:0] res1;
    logic [31:0] mag;
    logic [31:0] c10;
    logic [6:0]  frm;
    logic [5:0]  sec;
  } ctx_t;

  function automatic fmt_info_t non_drop(input logic [6:0] fps, input logic [31:0] fps_rcp,
                                         input logic [31:0] day, input logic [31:0] day_rcp);
    fmt_info_t r;
    r.is_drop  = 1'b0;
    r.drop     = 3'd0;
    r.fps      = fps;
    r.fps_rcp  = fps_rcp;
    r.day      = day;
    r.day_rcp  = day_rcp;
    r.fp10     = 32'(fps);
    r.fp10_rcp = fps_rcp;
    r.fpm      = 32'(fps);
    r.fpm_rcp  = fps_rcp;
    return r;
  endfunction

  function automatic fmt_info_t fmt_lookup(input logic [4:0] fmt);
    fmt_info_t r;
    r = '0;
    case (fmt)
      5'd1, 5'd2: r = non_drop(7'd24, 32'(TWO32 / 24), 32'd2073600, 32'(TWO32 / 2073600));
      5'd3:  r = non_drop(7'd25, 32'(TWO32 / 25), 32'd2160000, 32'(TWO32 / 2160000));
      5'd4, 5'd6: r = non_drop(7'd30, 32'(TWO32 / 30), 32'd2592000, 32'(TWO32 / 2592000));
      5'd5: begin
        r.is_drop  = 1'b1;
        r.drop     = 3'd2;
        r.fps      = 7'd30;
        r.fps_rcp  = 32'(TWO32 / 30);
        r.day      = 32'd2589408;
        r.day_rcp  = 32'(TWO32 / 2589408);
        r.fp10     = 32'd17982;
        r.fp10_rcp = 32'(TWO32 / 17982);
        r.fpm      = 32'd1798;
        r.fpm_rcp  = 32'(TWO32 / 1798);
      end
      5'd7, 5'd8: r = non_drop(7'd48, 32'(TWO32 / 48), 32'd4147200, 32'(TWO32 / 4147200));
      5'd9:  r = non_drop(7'd50, 32'(TWO32 / 50), 32'd4320000, 32'(TWO32 / 4320000));
      5'd10, 5'd12: r = non_drop(7'd60, 32'(TWO32 / 60), 32'd5184000, 32'(TWO32 / 5184000));
      5'd11: begin
        r.is_drop  = 1'b1;
        r.drop     = 3'd4;
        r.fps      = 7'd60;
        r.fps_rcp  = 32'(TWO32 / 60);
        r.day      = 32'd5178816;
        r.day_rcp  = 32'(TWO32 / 5178816);
        r.fp10     = 32'd35964;
        r.fp10_rcp = 32'(TWO32 / 35964);
        r.fpm      = 32'd3596;
        r.fpm_rcp  = 32'(TWO32 / 3596);
      end
      5'd13: r = non_drop(7'd72, 32'(TWO32 / 72), 32'd6220800, 32'(TWO32 / 6220800));
      5'd14: r = non_drop(7'd96, 32'(TWO32 / 96), 32'd8294400, 32'(TWO32 / 8294400));
      5'd15: r = non_drop(7'd100, 32'(TWO32 / 100), 32'd8640000, 32'(TWO32 / 8640000));
      5'd16: r = non_drop(7'd120, 32'(TWO32 / 120), 32'd10368000, 32'(TWO32 / 10368000));
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/smpte_timecode_frame_converter.sv -----
// Top level: pipelined SMPTE timecode converter between frame counts and h:m:s:f.
//
//  channel  | direction | handshake            | contents
//  s_*      | in        | s_tvalid / s_tready  | one conversion request word
//  m_*      | out       | m_tvalid / m_tready  | one conversion result word
//  cfg_*    | in        | cfg_valid / cfg_ready| rollover_disable bit
//
// A new word can be accepted every cycle while the skid register is empty. From
// acceptance to m_tvalid a word passes four front stages, six reciprocal dividers of
// three stages each, two glue stages and the output register.
// Reset clears every valid bit and the rollover register, nothing else.
// When m_tready is low a skid register takes one more word; only once it is
// full does the whole pipeline hold, so nothing is dropped or repeated.
module smpte_timecode_frame_converter import stc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // rate_code[4:0], frame_count[36:5], frame_offset[68:37], hours_in[84:69],
  // minutes_in[90:85], seconds_in[96:91], frames_in[103:97]
  input  logic [103:0]  s_tdata,
  // mode[1:0]
  input  logic [1:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // frame_count_out[31:0], hours_out[47:32], minutes_out[53:48], seconds_out[59:54],
  // frames_out[66:60], negative[67], zero fill[71:68]
  output logic [71:0]   m_tdata,
  // drop_frame[0], format_error[1]
  output logic [1:0]    m_tuser,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  localparam int SW = $bits(ctx_t);

  typedef struct packed {
    logic [71:0] tdata;
    logic [1:0]  tuser;
  } word_t;

  logic  rollover_disable;
  logic  en;
  logic  skid_v;
  word_t skid, pword;

  // The pipeline moves unless the skid register already holds a word.
  assign en        = !skid_v;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rollover_disable <= 1'b0;
    end else if (cfg_valid) begin
      rollover_disable <= cfg_data;
    end
  end

  // Front stage A: unpack, look up the format and form the count.
  ctx_t a_next, ctx_a, ctx_b, ctx_c, ctx_d;
  logic va, vb, vc, vd;
  logic [4:0] fmt_in;
  logic [31:0] cnt_in, off_in;

  assign fmt_in = s_tdata[4:0];
  assign cnt_in = s_tdata[36:5];
  assign off_in = s_tdata[68:37];

  always_comb begin
    a_next      = '0;
    a_next.mode = s_tuser;
    a_next.err  = (fmt_in == 5'd0) || (fmt_in > FMT_LAST);
    a_next.roll = rollover_disable;
    a_next.info = fmt_lookup(fmt_in);
    a_next.h    = s_tdata[84:69];
    a_next.m    = s_tdata[90:85];
    a_next.s    = s_tdata[96:91];
    a_next.f    = s_tdata[103:97];
    case (s_tuser)
      MODE_ADD: a_next.cnt = cnt_in + off_in;
      MODE_SUB: a_next.cnt = cnt_in - off_in;
      default:  a_next.cnt = cnt_in;
    endcase
  end

  // Stage B: seconds of the h:m:s input, dropped labels and count magnitude.
  ctx_t b_next;
  logic [13:0] mtens;

  always_comb begin
    b_next    = ctx_a;
    mtens     = (14'(ctx_a.m) * 14'd205) >> 11;
    b_next.t1 = 32'(ctx_a.h) * 32'd3600 + 32'(ctx_a.m) * 32'd60 + 32'(ctx_a.s);
    // 9 * (m / 10) + m % 10 is simply m - m / 10.
    b_next.dr = 32'(ctx_a.info.drop) *
                (32'(ctx_a.h) * 32'd54 + 32'(ctx_a.m) - 32'(mtens));
    b_next.mag = ctx_a.cnt[31] ? (32'd0 - ctx_a.cnt) : ctx_a.cnt;
  end

  ctx_t c_next, d_next;

  always_comb begin
    c_next      = ctx_b;
    c_next.res1 = ctx_b.t1 * 32'(ctx_b.info.fps);
    d_next      = ctx_c;
    d_next.res1 = ctx_c.res1 + 32'(ctx_c.f) - ctx_c.dr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_a <= a_next;
      ctx_b <= b_next;
      ctx_c <= c_next;
      ctx_d <= d_next;
    end
  end

  // Divider 1: magnitude modulo one day of frames, unless rollover is disabled.
  logic        v1;
  logic [31:0] q1, r1;
  logic [SW-1:0] sd1;

  stc_cdiv #(.W(CNT_W), .SW(SW)) u_div_day (
    .clk(clk), .rst(rst), .en(en), .in_valid(vd),
    .x(ctx_d.mag), .d(ctx_d.info.day), .rcp(ctx_d.info.day_rcp), .side_in(SW'(ctx_d)),
    .out_valid(v1), .q(q1), .r(r1), .side_out(sd1)
  );

  ctx_t ctx_e;
  always_comb begin
    ctx_e     = ctx_t'(sd1);
    ctx_e.mag = ctx_e.roll ? ctx_e.mag : r1;
  end

  // Divider 2: whole ten-minute blocks.
  logic        v2;
  logic [31:0] q2, r2;
  logic [SW-1:0] sd2;

  stc_cdiv #(.W(CNT_W), .SW(SW)) u_div_ten (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1),
    .x(ctx_e.mag), .d(ctx_e.info.fp10), .rcp(ctx_e.info.fp10_rcp), .side_in(SW'(ctx_e)),
    .out_valid(v2), .q(q2), .r(r2), .side_out(sd2)
  );

  // Stage F: remainder past the dropped labels of the block's first minute.
  ctx_t f_next, ctx_f;
  logic [31:0] x3_next, x3;
  logic vf;

  always_comb begin
    f_next     = ctx_t'(sd2);
    f_next.c10 = q2;
    x3_next    = (r2 >= 32'(f_next.info.drop)) ? r2 - 32'(f_next.info.drop) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_f <= f_next;
      x3    <= x3_next;
    end
  end

  // Divider 3: whole minutes after the first one of the block.
  logic        v3;
  logic [31:0] q3, r3;
  logic [SW-1:0] sd3;

  stc_cdiv #(.W(CNT_W), .SW(SW)) u_div_min (
    .clk(clk), .rst(rst), .en(en), .in_valid(vf),
    .x(x3), .d(ctx_f.info.fpm), .rcp(ctx_f.info.fpm_rcp), .side_in(SW'(ctx_f)),
    .out_valid(v3), .q(q3), .r(r3), .side_out(sd3)
  );

  // Stage G: put the skipped labels back into the count.
  ctx_t g_next, ctx_g;
  logic vg;
  logic [5:0] blk_drop;

  always_comb begin
    g_next   = ctx_t'(sd3);
    blk_drop = 6'(g_next.info.drop) * 6'd9;
    if (g_next.info.is_drop) begin
      g_next.mag = g_next.mag + g_next.c10 * 32'(blk_drop) + q3 * 32'(g_next.info.drop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (en) begin
      vg <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_g <= g_next;
    end
  end

  // Divider 4: seconds and frame label.
  logic        v4;
  logic [31:0] q4, r4;
  logic [SW-1:0] sd4;

  stc_cdiv #(.W(CNT_W), .SW(SW)) u_div_fps (
    .clk(clk), .rst(rst), .en(en), .in_valid(vg),
    .x(ctx_g.mag), .d(32'(ctx_g.info.fps)), .rcp(ctx_g.info.fps_rcp), .side_in(SW'(ctx_g)),
    .out_valid(v4), .q(q4), .r(r4), .side_out(sd4)
  );

  ctx_t ctx_h;
  always_comb begin
    ctx_h     = ctx_t'(sd4);
    ctx_h.frm = r4[6:0];
  end

  // Divider 5: minutes and seconds.
  logic        v5;
  logic [31:0] q5, r5;
  logic [SW-1:0] sd5;

  stc_cdiv #(.W(CNT_W), .SW(SW)) u_div_sec (
    .clk(clk), .rst(rst), .en(en), .in_valid(v4),
    .x(q4), .d(BASE60), .rcp(BASE60_RCP), .side_in(SW'(ctx_h)),
    .out_valid(v5), .q(q5), .r(r5), .side_out(sd5)
  );

  ctx_t ctx_i;
  always_comb begin
    ctx_i     = ctx_t'(sd5);
    ctx_i.sec = r5[5:0];
  end

  // Divider 6: hours and minutes.
  logic        v6;
  logic [31:0] q6, r6;
  logic [SW-1:0] sd6;

  stc_cdiv #(.W(CNT_W), .SW(SW)) u_div_hour (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5),
    .x(q5), .d(BASE60), .rcp(BASE60_RCP), .side_in(SW'(ctx_i)),
    .out_valid(v6), .q(q6), .r(r6), .side_out(sd6)
  );

  // Result word: unknown formats give zeros and the error flag; a count request
  // echoes its h:m:s:f fields.
  ctx_t ctx_j;
  always_comb begin
    ctx_j = ctx_t'(sd6);
    pword = '0;
    if (ctx_j.err) begin
      pword.tuser[1] = 1'b1;
    end else if (ctx_j.mode == MODE_TO_COUNT) begin
      pword.tdata[31:0]  = ctx_j.res1;
      pword.tdata[47:32] = ctx_j.h;
      pword.tdata[53:48] = ctx_j.m;
      pword.tdata[59:54] = ctx_j.s;
      pword.tdata[66:60] = ctx_j.f;
      pword.tdata[67]    = ctx_j.res1[31];
      pword.tuser[0]     = ctx_j.info.is_drop;
    end else begin
      pword.tdata[31:0]  = ctx_j.cnt;
      pword.tdata[47:32] = q6[15:0];
      pword.tdata[53:48] = r6[5:0];
      pword.tdata[59:54] = ctx_j.sec;
      pword.tdata[66:60] = ctx_j.frm;
      pword.tdata[67]    = ctx_j.cnt[31];
      pword.tuser[0]     = ctx_j.info.is_drop;
    end
  end

  // Output register with one skid word behind it.
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (skid_v) begin
      if (out_free) begin
        m_tvalid <= 1'b1;
        skid_v   <= 1'b0;
      end
    end else if (out_free) begin
      m_tvalid <= v6;
    end else if (v6) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_free) begin
        m_tdata <= skid.tdata;
        m_tuser <= skid.tuser;
      end
    end else if (out_free) begin
      m_tdata <= pword.tdata;
      m_tuser <= pword.tuser;
    end else begin
      skid <= pword;
    end
  end

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
    else $error("format error word carries nonzero fields");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[67] == m_tdata[31])
    else $error("negative flag differs from count sign");

  a_frame_rem: assert property (@(posedge clk) disable iff (rst)
    v4 && !ctx_h.err |-> r4 < 32'(ctx_h.info.fps))
    else $error("frame label not below the nominal rate");

  a_min_rem: assert property (@(posedge clk) disable iff (rst)
    v6 |-> r6 < BASE60)
    else $error("minutes remainder out of range");
`endif

endmodule

// ----- hdl/stc_cdiv.sv -----
// Three-stage divider by a table divisor using a reciprocal multiply and one correction.
module stc_cdiv import stc_pkg::*; #(
  parameter int W  = CNT_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  x,
  input  logic [W-1:0]  d,
  input  logic [W-1:0]  rcp,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [W-1:0]  q,
  output logic [W-1:0]  r,
  output logic [SW-1:0] side_out
);

  logic          v1, v2;
  logic [2*W-1:0] prod;
  logic [W-1:0]  x1, d1, q2, r2, d2;
  logic [SW-1:0] side1, side2;
  logic [W-1:0]  q0;

  assign q0 = prod[2*W-1:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // The estimate is low by at most one, so a single compare and subtract fixes it.
  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= (2*W)'(x) * (2*W)'(rcp);
      x1    <= x;
      d1    <= d;
      side1 <= side_in;
      q2    <= q0;
      r2    <= x1 - W'(q0 * d1);
      d2    <= d1;
      side2 <= side1;
      if (r2 >= d2) begin
        q <= q2 + W'(1);
        r <= r2 - d2;
      end else begin
        q <= q2;
        r <= r2;
      end
      side_out <= side2;
    end
  end

endmodule
